>>> hdl/bps_pkg.sv
// Shared types and codes for the battery power supervisor.
// Depends on nothing; bps_cfg_regs, bps_eval and the top level import it.
`timescale 1ns / 1ps

package bps_pkg;

    // transaction function codes
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_LINK   = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CRIT_PCT  = 3'd0;
    localparam logic [2:0] REG_LIMIT_PCT = 3'd1;
    localparam logic [2:0] REG_WARN_PCT  = 3'd2;
    localparam logic [2:0] REG_BASE_BRT  = 3'd3;
    localparam logic [2:0] REG_TX_EN     = 3'd4;
    localparam logic [2:0] REG_PWR_DLY   = 3'd5;

    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        STG_NORMAL   = 2'd0,
        STG_WARN     = 2'd1,
        STG_LIMIT    = 2'd2,
        STG_CRITICAL = 2'd3
    } t_stage;

    typedef enum logic [2:0] {
        SYS_BOOT     = 3'd0,
        SYS_CONFIG   = 3'd1,
        SYS_ONLINE   = 3'd2,
        SYS_DEGRADED = 3'd3,
        SYS_CRITICAL = 3'd4
    } t_sys_state;

    typedef struct packed {
        logic [6:0]  crit_pct;
        logic [6:0]  limit_pct;
        logic [6:0]  warn_pct;
        logic [7:0]  base_brightness;
        logic        tx_enable;
        logic [15:0] power_off_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] batt_pct;
        logic       wifi_connected;
        logic       ap_mode;
        logic       mqtt_connected;
    } t_in_item;

    typedef struct packed {
        logic [1:0] stage;
        logic       stage_changed;
        logic [1:0] beep_code;
        logic [2:0] sys_state;
        logic       sys_state_changed;
        logic [7:0] led_level;
        logic       tx_allowed;
        logic       power_off;
    } t_out_item;

    // link bits: [0] wifi, [1] ap mode, [2] broker session
    typedef struct packed {
        logic [6:0]  smoothed_pct;
        t_stage      stage;
        t_sys_state  sys_state;
        logic [2:0]  link_flags;
        logic [15:0] critical_ms;
        logic        power_cut;
    } t_state;

endpackage

>>> hdl/bps_in_if.sv
// Input channel of the battery power supervisor: valid/ready plus item fields.
// No dependencies.
`timescale 1ns / 1ps

interface bps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [6:0] batt_pct;
    logic       wifi_connected;
    logic       ap_mode;
    logic       mqtt_connected;

    modport source (output valid, func, batt_pct, wifi_connected, ap_mode,
                    mqtt_connected, input ready);
    modport sink   (input valid, func, batt_pct, wifi_connected, ap_mode,
                    mqtt_connected, output ready);
endinterface

>>> hdl/bps_out_if.sv
// Result channel of the battery power supervisor: valid/ready plus result fields.
// No dependencies.
`timescale 1ns / 1ps

interface bps_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] stage;
    logic       stage_changed;
    logic [1:0] beep_code;
    logic [2:0] sys_state;
    logic       sys_state_changed;
    logic [7:0] led_level;
    logic       tx_allowed;
    logic       power_off;

    modport source (output valid, stage, stage_changed, beep_code, sys_state,
                    sys_state_changed, led_level, tx_allowed, power_off,
                    input ready);
    modport sink   (input valid, stage, stage_changed, beep_code, sys_state,
                    sys_state_changed, led_level, tx_allowed, power_off,
                    output ready);
endinterface

>>> hdl/bps_cfg_regs.sv
// APB-style configuration registers of the battery power supervisor.
// Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bps_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bps_pkg::t_cfg               o_cfg
);
    import bps_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crit_pct           <= 7'd5;
            r_cfg.limit_pct          <= 7'd10;
            r_cfg.warn_pct           <= 7'd20;
            r_cfg.base_brightness    <= 8'd255;
            r_cfg.tx_enable          <= 1'b1;
            r_cfg.power_off_delay_ms <= 16'd5000;
        end else if (w_wr) begin
            case (w_idx)
                REG_CRIT_PCT:  r_cfg.crit_pct           <= pwdata[6:0];
                REG_LIMIT_PCT: r_cfg.limit_pct          <= pwdata[6:0];
                REG_WARN_PCT:  r_cfg.warn_pct           <= pwdata[6:0];
                REG_BASE_BRT:  r_cfg.base_brightness    <= pwdata[7:0];
                REG_TX_EN:     r_cfg.tx_enable          <= pwdata[0];
                REG_PWR_DLY:   r_cfg.power_off_delay_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CRIT_PCT:  prdata = {25'd0, r_cfg.crit_pct};
            REG_LIMIT_PCT: prdata = {25'd0, r_cfg.limit_pct};
            REG_WARN_PCT:  prdata = {25'd0, r_cfg.warn_pct};
            REG_BASE_BRT:  prdata = {24'd0, r_cfg.base_brightness};
            REG_TX_EN:     prdata = {31'd0, r_cfg.tx_enable};
            REG_PWR_DLY:   prdata = {16'd0, r_cfg.power_off_delay_ms};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/bps_eval.sv
// Per-transaction evaluation: next supervisor state and the result fields.
// Purely combinational; depends on bps_pkg.
`timescale 1ns / 1ps

module bps_eval (
    input  bps_pkg::t_state    i_state,
    input  bps_pkg::t_in_item  i_item,
    input  bps_pkg::t_cfg      i_cfg,
    output bps_pkg::t_state    o_state,
    output bps_pkg::t_out_item o_result
);
    import bps_pkg::*;

    localparam logic [7:0] LED_KNEE_WARN  = 8'd40;
    localparam logic [7:0] LED_FLOOR_WARN = 8'd20;
    localparam logic [7:0] LED_KNEE_LIM   = 8'd30;
    localparam logic [7:0] LED_FLOOR_LIM  = 8'd10;
    // x/10 == (x*6554)>>16 for x below 16384
    localparam logic [23:0] RECIP_TEN     = 24'd6554;

    function automatic t_stage stage_of(input logic [6:0] p, input t_cfg c);
        t_stage s;
        if (p <= c.crit_pct)       s = STG_CRITICAL;
        else if (p <= c.limit_pct) s = STG_LIMIT;
        else if (p <= c.warn_pct)  s = STG_WARN;
        else                       s = STG_NORMAL;
        return s;
    endfunction

    logic [10:0] w_blend;
    logic [23:0] w_prod;
    logic [6:0]  w_smooth;
    t_stage      w_new_stage;
    t_state      w_nxt;
    t_sys_state  w_sys;
    logic        w_stg_chg;
    logic [1:0]  w_beep;
    logic        w_sys_chg;
    logic [7:0]  w_led1;
    logic [7:0]  w_led2;
    logic        w_at_limit;

    assign w_blend     = 11'(i_state.smoothed_pct) * 11'd7 + 11'(i_item.batt_pct) * 11'd3;
    assign w_prod      = 24'(w_blend) * RECIP_TEN;
    assign w_smooth    = w_prod[22:16];
    assign w_new_stage = stage_of(w_smooth, i_cfg);

    always_comb begin
        w_nxt     = i_state;
        w_stg_chg = 1'b0;
        w_beep    = 2'd0;
        case (i_item.func)
            FUNC_SAMPLE: begin
                w_nxt.smoothed_pct = w_smooth;
                if (w_new_stage != i_state.stage) begin
                    w_nxt.stage = w_new_stage;
                    w_stg_chg   = 1'b1;
                    w_beep      = w_new_stage;
                end
            end
            FUNC_TICK: begin
                if (i_state.sys_state == SYS_CRITICAL && i_state.critical_ms != 16'hFFFF)
                    w_nxt.critical_ms = i_state.critical_ms + 16'd1;
            end
            FUNC_LINK: begin
                w_nxt.link_flags = {i_item.mqtt_connected, i_item.ap_mode,
                                    i_item.wifi_connected};
            end
            default: ;
        endcase

        if (w_nxt.stage == STG_CRITICAL)                    w_sys = SYS_CRITICAL;
        else if (w_nxt.link_flags[1])                       w_sys = SYS_CONFIG;
        else if (w_nxt.link_flags[0] && w_nxt.link_flags[2]
                 && w_nxt.stage == STG_NORMAL)              w_sys = SYS_ONLINE;
        else                                                w_sys = SYS_DEGRADED;

        w_sys_chg       = (w_sys != i_state.sys_state);
        w_nxt.sys_state = w_sys;
        if (w_sys != SYS_CRITICAL)
            w_nxt.critical_ms = 16'd0;
        else if (w_nxt.critical_ms > i_cfg.power_off_delay_ms)
            w_nxt.power_cut = 1'b1;
    end

    // LED halving with floors; limit and critical apply both steps
    assign w_at_limit = (w_nxt.stage == STG_LIMIT) || (w_nxt.stage == STG_CRITICAL);

    always_comb begin
        w_led1 = i_cfg.base_brightness;
        if (w_nxt.stage != STG_NORMAL)
            w_led1 = (i_cfg.base_brightness > LED_KNEE_WARN) ?
                     (i_cfg.base_brightness >> 1) : LED_FLOOR_WARN;
        w_led2 = w_led1;
        if (w_at_limit)
            w_led2 = (w_led1 > LED_KNEE_LIM) ? (w_led1 >> 1) : LED_FLOOR_LIM;
    end

    assign o_state                    = w_nxt;
    assign o_result.stage             = w_nxt.stage;
    assign o_result.stage_changed     = w_stg_chg;
    assign o_result.beep_code         = w_beep;
    assign o_result.sys_state         = w_nxt.sys_state;
    assign o_result.sys_state_changed = w_sys_chg;
    assign o_result.led_level         = w_led2;
    assign o_result.tx_allowed        = i_cfg.tx_enable && !w_at_limit;
    assign o_result.power_off         = w_nxt.power_cut;

endmodule

>>> hdl/battery_power_supervisor_unit.sv
// Battery power supervisor, top level: input register, state, result register.
// Depends on bps_pkg, bps_in_if, bps_out_if, bps_cfg_regs and bps_eval.
//
// Usage:
//   i_in  carries one transaction per item: a battery sample (func 0), a
//         one millisecond tick (func 1) or a link status update (func 2).
//   o_out returns exactly one result transaction per input transaction,
//         in order: stage, beep code, system state, LED level, tx permit
//         and the latched power-off flag.
//   APB   port sets thresholds, brightness, tx enable and power-off delay;
//         write it only while no transaction is in flight. pready is tied
//         high, reads are zero-wait.
// Timing: an item lands in the input register at its accept edge and its
//   result is loaded into the output register once that slot is free or
//   being drained, and that register drives o_out.valid. The evaluate stage
//   (one constant multiply for the smoothing divide, three threshold compares)
//   is combinational; one item per cycle is sustained while o_out.ready is high.
// Stall: with o_out.ready low the result holds, the input register keeps
//   one item and i_in.ready drops once both are full; nothing is lost.
// Reset (i_rst_n low, synchronous): both stages empty, smoothed percent 100,
//   stage normal, system state boot, registers at their defaults.
`timescale 1ns / 1ps

module battery_power_supervisor_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bps_in_if.sink                      i_in,
    bps_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bps_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bps_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out;
    logic      w_accept;
    logic      w_adv;

    bps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bps_eval u_eval (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // evaluate moves forward when the result slot is free or being drained
    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.func           <= i_in.func;
            r_in.batt_pct       <= i_in.batt_pct;
            r_in.wifi_connected <= i_in.wifi_connected;
            r_in.ap_mode        <= i_in.ap_mode;
            r_in.mqtt_connected <= i_in.mqtt_connected;
        end
    end

    // supervisor state, updated once per evaluated transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.smoothed_pct <= 7'd100;
            r_state.stage        <= STG_NORMAL;
            r_state.sys_state    <= SYS_BOOT;
            r_state.link_flags   <= 3'd0;
            r_state.critical_ms  <= 16'd0;
            r_state.power_cut    <= 1'b0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.stage             = r_out.stage;
    assign o_out.stage_changed     = r_out.stage_changed;
    assign o_out.beep_code         = r_out.beep_code;
    assign o_out.sys_state         = r_out.sys_state;
    assign o_out.sys_state_changed = r_out.sys_state_changed;
    assign o_out.led_level         = r_out.led_level;
    assign o_out.tx_allowed        = r_out.tx_allowed;
    assign o_out.power_off         = r_out.power_off;

    // power cut is latched until reset
    a_cut_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.power_cut |=> r_state.power_cut)
        else $error("power cut released");

    // tick counter only runs in critical power state
    a_ms_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sys_state != SYS_CRITICAL) |-> (r_state.critical_ms == 16'd0))
        else $error("critical_ms nonzero outside critical state");

    // beep follows the stage only on a change
    a_beep_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.beep_code == (r_out.stage_changed ? r_out.stage : 2'd0)))
        else $error("beep code inconsistent with stage change");

    // tx never permitted at limit or critical
    a_tx_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.tx_allowed) |-> (r_out.stage[1] == 1'b0))
        else $error("tx allowed at limit stage or above");

    // a held item is not dropped while the result side stalls
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("input register lost a transaction");

endmodule
